// ===== rtl/sync_length_crc_frame_parser_macros.svh =====
// Assertion macros used by the frame parser RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SYNC_LENGTH_CRC_FRAME_PARSER_MACROS_SVH
`define SYNC_LENGTH_CRC_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLCFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/slcfp_pkg.sv =====
// Shared types and constants of the sync/length/CRC frame parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slcfp_pkg;

  localparam logic [7:0]  SYNC0    = 8'hA5;
  localparam logic [7:0]  SYNC1    = 8'h5A;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [6:0] {
    PH_SYNC0 = 7'b0000001,
    PH_SYNC1 = 7'b0000010,
    PH_LEN0  = 7'b0000100,
    PH_LEN1  = 7'b0001000,
    PH_PAY   = 7'b0010000,
    PH_CRC0  = 7'b0100000,
    PH_CRC1  = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [9:0]  byte_index;
    logic [10:0] frame_len;
    logic        crc_ok;
    logic [15:0] received_crc;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/slcfp_if.sv =====
// Valid/ready stream interfaces for the frame parser input and result channels.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface slcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcfp_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  payload_byte;
  logic [9:0]  byte_index;
  logic [10:0] frame_len;
  logic        crc_ok;
  logic [15:0] received_crc;

  modport source (output valid, output out_kind, output payload_byte, output byte_index,
                  output frame_len, output crc_ok, output received_crc, input ready);
  modport sink (input valid, input out_kind, input payload_byte, input byte_index,
                input frame_len, input crc_ok, input received_crc, output ready);
endinterface

`default_nettype wire

// ===== rtl/slcfp_crc16.sv =====
// One-byte CRC16-CCITT update (poly 0x1021, MSB first), purely combinational.
// Depends on slcfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slcfp_crc16 (
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  data_i,
  output logic      [15:0] crc_o
);
  import slcfp_pkg::*;

  logic [15:0] c;

  always_comb begin
    c = crc_i ^ {data_i, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

// ===== rtl/slcfp_parse.sv =====
// Input register and framing state machine of the frame parser.
// Depends on slcfp_pkg, slcfp_crc16 and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sync_length_crc_frame_parser_macros.svh"

module slcfp_parse #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [7:0]        in_byte_i,
  output logic                   in_ready_o,
  input  wire logic              slot_free_i,
  output logic                   res_valid_o,
  output slcfp_pkg::res_t        res_o
);
  import slcfp_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEN + 1);

  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;
  phase_e           phase_q, phase_d;
  logic [7:0]       len_lo_q, len_lo_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_lo_q, crc_lo_d;
  logic [15:0]      crc_next;
  logic [15:0]      len_full;
  logic [15:0]      len_ext;
  logic [15:0]      cnt_ext;
  logic [15:0]      rx_crc;
  logic             emits;
  logic             adv;

  slcfp_crc16 u_crc (
    .crc_i  (crc_q),
    .data_i (s1_byte_q),
    .crc_o  (crc_next)
  );

  assign emits      = (phase_q == PH_PAY) || (phase_q == PH_CRC1);
  assign adv        = s1_valid_q && (!emits || slot_free_i);
  assign in_ready_o = !s1_valid_q || adv;

  assign len_full = {s1_byte_q, len_lo_q};
  assign len_ext  = 16'(len_q);
  assign cnt_ext  = 16'(cnt_q);
  assign rx_crc   = {s1_byte_q, crc_lo_q};

  always_comb begin
    phase_d  = phase_q;
    len_lo_d = len_lo_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    res_o    = '0;
    res_o.frame_len = len_ext[10:0];
    unique case (phase_q)
      PH_SYNC0: begin
        if (s1_byte_q == SYNC0) begin
          phase_d = PH_SYNC1;
        end
      end
      PH_SYNC1: begin
        // A wrong second byte is not retried as a first sync byte.
        phase_d = (s1_byte_q == SYNC1) ? PH_LEN0 : PH_SYNC0;
      end
      PH_LEN0: begin
        len_lo_d = s1_byte_q;
        phase_d  = PH_LEN1;
      end
      PH_LEN1: begin
        len_d = LEN_W'(len_full);
        cnt_d = '0;
        crc_d = CRC_INIT;
        if ({1'b0, len_full} > 17'(MAX_LEN)) begin
          phase_d = PH_SYNC0;
        end else if (len_full == 16'h0000) begin
          phase_d = PH_CRC0;
        end else begin
          phase_d = PH_PAY;
        end
      end
      PH_PAY: begin
        res_o.out_kind     = KIND_PAYLOAD;
        res_o.payload_byte = s1_byte_q;
        res_o.byte_index   = cnt_ext[9:0];
        crc_d = crc_next;
        cnt_d = cnt_q + 1'b1;
        if (cnt_d == len_q) begin
          phase_d = PH_CRC0;
        end
      end
      PH_CRC0: begin
        crc_lo_d = s1_byte_q;
        phase_d  = PH_CRC1;
      end
      PH_CRC1: begin
        res_o.out_kind     = KIND_VERDICT;
        res_o.crc_ok       = (crc_q == rx_crc);
        res_o.received_crc = rx_crc;
        phase_d = PH_SYNC0;
      end
      default: begin
        phase_d = PH_SYNC0;
      end
    endcase
  end

  assign res_valid_o = adv && emits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= PH_SYNC0;
      len_lo_q   <= '0;
      len_q      <= '0;
      cnt_q      <= '0;
      crc_q      <= CRC_INIT;
      crc_lo_q   <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        phase_q  <= phase_d;
        len_lo_q <= len_lo_d;
        len_q    <= len_d;
        cnt_q    <= cnt_d;
        crc_q    <= crc_d;
        crc_lo_q <= crc_lo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= in_byte_i;
    end
  end

  `SLCFP_ASSERT_NOW(a_res_phase, res_valid_o,
    (phase_q == PH_PAY) || (phase_q == PH_CRC1), "result outside payload or CRC phase")
  `SLCFP_ASSERT_NOW(a_cnt_below_len, phase_q == PH_PAY,
    cnt_q < len_q, "payload counter reached the declared length")
  `SLCFP_ASSERT_NEXT(a_verdict_rehunt, adv && (phase_q == PH_CRC1),
    phase_q == PH_SYNC0, "parser did not return to hunting after a verdict")

endmodule

`default_nettype wire

// ===== rtl/sync_length_crc_frame_parser.sv =====
// The parser takes one received byte per item and can accept a byte in every cycle; a byte
// passes an input register and, if it yields a result, the result register, so a payload
// byte or verdict is offered on the result channel once its byte has passed the input
// register. The rate is set by the combinational CRC16 byte update between those
// registers. Input stalls only when the byte in the input register yields a result and the
// result register is still held.
// Frames longer than MAX_LEN are dropped without a result; consumers discard payload
// bytes of frames whose verdict reports crc_ok low.
// Top level; depends on slcfp_pkg, slcfp_if and slcfp_parse.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_crc_frame_parser #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  slcfp_in_if.sink    rx_i,
  slcfp_out_if.source res_o
);
  import slcfp_pkg::*;

  logic res_valid;
  res_t res;
  logic slot_free;
  logic out_valid_q, out_valid_d;
  res_t out_q;

  assign slot_free = !out_valid_q || res_o.ready;

  slcfp_parse #(
    .MAX_LEN (MAX_LEN)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_byte_i   (rx_i.rx_byte),
    .in_ready_o  (rx_i.ready),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_d = res_valid || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.out_kind     = out_q.out_kind;
  assign res_o.payload_byte = out_q.payload_byte;
  assign res_o.byte_index   = out_q.byte_index;
  assign res_o.frame_len    = out_q.frame_len;
  assign res_o.crc_ok       = out_q.crc_ok;
  assign res_o.received_crc = out_q.received_crc;

endmodule

`default_nettype wire
